// ===== hw/rtl/igfa_pkg.sv =====
// ----------------------------------------------------------------------------
// igfa_pkg
// Shared constants and controller/datapath interface types for the idle gap
// frame assembler.
// ----------------------------------------------------------------------------
package igfa_pkg;

    localparam int FRAME_LEN_DEF = 64;

    localparam logic [7:0] IDLE_TICKS_RST = 8'd5;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic cfg_wr;
        logic byte_wr;
        logic tick_dec;
        logic issue;
    } cmd_t;

    typedef struct packed {
        logic timer_zero;
        logic count_zero;
        logic out_free;
        logic issue_last;
    } sts_t;

endpackage

// ===== hw/rtl/igfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// igfa_ctrl
// Sequencer: accepts items while idle, decodes them into datapath commands
// and walks the frame drain one byte per free output slot.
// ----------------------------------------------------------------------------
module igfa_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          op,
    input  logic          cfg_valid,
    input  igfa_pkg::sts_t sts,
    output logic          in_stall,
    output logic          cfg_ready,
    output igfa_pkg::cmd_t cmd
);

    localparam logic [0:0] ST_IDLE  = 1'b0;
    localparam logic [0:0] ST_DRAIN = 1'b1;

    logic [0:0] state_reg;
    logic [0:0] state_next;
    logic       idle;
    logic       in_take;

    assign idle      = (state_reg == ST_IDLE);
    assign in_take   = in_valid && idle;
    assign in_stall  = !idle;
    assign cfg_ready = idle;

    always_comb
    begin
        cmd            = '0;
        cmd.cfg_wr     = cfg_valid && idle;
        cmd.byte_wr    = in_take && (op == igfa_pkg::OP_BYTE);
        cmd.tick_dec   = in_take && (op == igfa_pkg::OP_TICK) && !sts.timer_zero;
        cmd.issue      = (state_reg == ST_DRAIN) && sts.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                // A tick that finds the timer expired with bytes held starts a drain.
                if (in_take && (op == igfa_pkg::OP_TICK) && sts.timer_zero
                    && !sts.count_zero)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (cmd.issue && sts.issue_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/igfa_datapath.sv =====
// ----------------------------------------------------------------------------
// igfa_datapath
// Frame store memory, byte count, idle timer, reload register and the
// registered output stage that the memory read port feeds.
// ----------------------------------------------------------------------------
module igfa_datapath
#(
    parameter int FRAME_LEN = igfa_pkg::FRAME_LEN_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  igfa_pkg::cmd_t cmd,
    input  logic [7:0]     rx_byte,
    input  logic [7:0]     cfg_data,
    input  logic           out_stall,
    output igfa_pkg::sts_t sts,
    output logic           out_valid,
    output logic [7:0]     frame_byte,
    output logic           frame_last
);

    localparam int SLOTS = FRAME_LEN - 1;
    localparam int CW    = $clog2(FRAME_LEN);
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

    logic [7:0]    mem [SLOTS];
    logic [CW-1:0] byte_count_reg;
    logic [CW-1:0] byte_count_next;
    logic [7:0]    idle_timer_reg;
    logic [7:0]    idle_timer_next;
    logic [7:0]    idle_ticks_reg;
    logic [AW-1:0] rd_idx_reg;
    logic [AW-1:0] rd_idx_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [7:0]    rd_data_reg;
    logic          last_reg;
    logic [AW-1:0] wr_addr;
    logic          is_last;

    // Once the store is full, further bytes land in the final slot.
    assign wr_addr = (byte_count_reg == SLOTS_C) ? AW'(SLOTS - 1) : byte_count_reg[AW-1:0];
    assign is_last = (CW'(rd_idx_reg) == (byte_count_reg - CW'(1)));

    assign sts.timer_zero = (idle_timer_reg == 8'd0);
    assign sts.count_zero = (byte_count_reg == '0);
    assign sts.out_free   = !out_valid_reg || !out_stall;
    assign sts.issue_last = is_last;

    assign out_valid  = out_valid_reg;
    assign frame_byte = rd_data_reg;
    assign frame_last = last_reg;

    always_comb
    begin
        byte_count_next = byte_count_reg;
        idle_timer_next = idle_timer_reg;
        rd_idx_next     = rd_idx_reg;
        out_valid_next  = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.byte_wr)
        begin
            if (byte_count_reg != SLOTS_C)
            begin
                byte_count_next = byte_count_reg + CW'(1);
            end
            idle_timer_next = idle_ticks_reg;
        end
        if (cmd.tick_dec)
        begin
            idle_timer_next = idle_timer_reg - 8'd1;
        end
        if (cmd.issue)
        begin
            out_valid_next = 1'b1;
            if (is_last)
            begin
                rd_idx_next     = '0;
                byte_count_next = '0;
            end
            else
            begin
                rd_idx_next = rd_idx_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            idle_timer_reg <= '0;
            idle_ticks_reg <= igfa_pkg::IDLE_TICKS_RST;
            rd_idx_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            idle_timer_reg <= idle_timer_next;
            rd_idx_reg     <= rd_idx_next;
            out_valid_reg  <= out_valid_next;
            if (cmd.cfg_wr)
            begin
                idle_ticks_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.byte_wr)
        begin
            mem[wr_addr] <= rx_byte;
        end
    end

    // The read register doubles as the output payload; it only loads when the
    // output slot is free, so a stalled transaction holds.
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            rd_data_reg <= mem[rd_idx_reg];
            last_reg    <= is_last;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= SLOTS_C)
        else $error("byte count exceeds store depth");

    a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue && is_last) |=> (byte_count_reg == '0) && (rd_idx_reg == '0))
        else $error("count or read index not cleared after final byte");

    a_issue_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (!out_valid_reg || !out_stall))
        else $error("read issued while output stage is occupied");

    a_tick_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tick_dec |-> (idle_timer_reg != 8'd0))
        else $error("idle timer decremented at zero");

    a_issue_held: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (byte_count_reg != '0))
        else $error("read issued with empty store");

endmodule

// ===== hw/rtl/idle_gap_frame_assembler.sv =====
// A byte or timer-decrement tick is absorbed when accepted; a draining tick
// enters the drain state, which issues one byte per cycle while the output
// is free. Throughput: one item per cycle, except that a drain holds in_stall
// for n bytes plus any output stall, paced by the single frame store read port.
// Reset: count, timer and control clear, idle_ticks returns to 5, and the
// frame store contents are left as they are (never read before written).
// ----------------------------------------------------------------------------
// idle_gap_frame_assembler
// Collects received bytes into a frame and releases the whole frame once the
// line has stayed idle for the configured number of ticks.
// ----------------------------------------------------------------------------
module idle_gap_frame_assembler
#(
    parameter int FRAME_LEN = igfa_pkg::FRAME_LEN_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       op,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] frame_byte,
    output logic       frame_last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    igfa_pkg::cmd_t cmd;
    igfa_pkg::sts_t sts;

    igfa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .op        (op),
        .cfg_valid (cfg_valid),
        .sts       (sts),
        .in_stall  (in_stall),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    igfa_datapath
    #(
        .FRAME_LEN (FRAME_LEN)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .rx_byte    (rx_byte),
        .cfg_data   (cfg_data),
        .out_stall  (out_stall),
        .sts        (sts),
        .out_valid  (out_valid),
        .frame_byte (frame_byte),
        .frame_last (frame_last)
    );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives byte and tick transactions into the idle gap frame assembler, tracks
// the expected frames in a scoreboard and checks every emitted frame byte.
// ----------------------------------------------------------------------------

class frame_scoreboard;

    localparam int SLOTS = igfa_pkg::FRAME_LEN_DEF - 1;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_beat_t;

    logic [7:0]  store [0:SLOTS-1];
    int          held;
    logic [7:0]  timer;
    logic [7:0]  reload;
    frame_beat_t frame_queue [$];
    int          errors;

    function new();
        held   = 0;
        timer  = 8'd0;
        reload = igfa_pkg::IDLE_TICKS_RST;
        errors = 0;
    endfunction

    function void set_reload(logic [7:0] value);
        reload = value;
    endfunction

    function int pending();
        return frame_queue.size();
    endfunction

    // Updates the assembler state for one accepted input transaction and
    // queues the bytes of a released frame.
    function void absorb_item(logic kind, logic [7:0] data);
        frame_beat_t beat;
        int          slot;
        if (kind == igfa_pkg::OP_BYTE) begin
            slot = (held > SLOTS - 1) ? SLOTS - 1 : held;
            store[slot] = data;
            if (held < SLOTS)
                held++;
            timer = reload;
        end
        else if (timer != 8'd0) begin
            timer = timer - 8'd1;
        end
        else if (held != 0) begin
            for (int k = 0; k < held; k++) begin
                beat.data = store[k];
                beat.last = (k == held - 1);
                frame_queue.push_back(beat);
            end
            held = 0;
        end
    endfunction

    task report(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    task check_byte(logic [7:0] data, logic last);
        frame_beat_t beat;
        if (frame_queue.size() == 0) begin
            report($sformatf("unexpected frame byte %02h last %0b", data, last));
        end
        else begin
            beat = frame_queue.pop_front();
            if (data !== beat.data)
                report($sformatf("frame_byte %02h, expected %02h", data, beat.data));
            if (last !== beat.last)
                report($sformatf("frame_last %0b, expected %0b", last, beat.last));
        end
    endtask

endclass

module testbench;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic       op        = igfa_pkg::OP_BYTE;
    logic [7:0] rx_byte   = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] frame_byte;
    logic       frame_last;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data  = 8'd0;

    frame_scoreboard scoreboard = new();

    int items_sent  = 0;
    int bytes_seen  = 0;
    bit gap_en      = 1'b1;
    bit held_once   = 1'b0;
    int hold_left   = 0;

    idle_gap_frame_assembler DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .frame_last (frame_last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Handshake signals are sampled at the falling edge, where everything
    // driven at the rising edge has settled.
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall) begin
            scoreboard.check_byte(frame_byte, frame_last);
            bytes_seen++;
        end
    end

    // Receiver: random stalls, plus one long hold-off once traffic is flowing
    // so that a drain backs up into the input channel.
    always @(posedge clk)
    begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!held_once && bytes_seen >= 20) begin
            held_once <= 1'b1;
            hold_left <= 300;
            out_stall <= 1'b1;
        end
        else if (gap_en && $urandom_range(99) < 23) begin
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= 1'b0;
        end
    end

    task automatic send_item(input logic kind, input logic [7:0] data);
        if (gap_en) begin
            while ($urandom_range(99) < 23) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        op       <= kind;
        rx_byte  <= data;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        scoreboard.absorb_item(kind, data);
        @(posedge clk);
        items_sent++;
    endtask

    task automatic send_ticks(input int count);
        for (int i = 0; i < count; i++)
            send_item(igfa_pkg::OP_TICK, 8'($urandom));
    endtask

    // A run of bytes with the occasional stray tick, then either enough ticks
    // to release the frame or too few, so the next run extends it.
    task automatic send_frame(input int len, input int reload);
        int ticks;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(7) == 0)
                send_item(igfa_pkg::OP_TICK, 8'($urandom));
            send_item(igfa_pkg::OP_BYTE, 8'($urandom));
        end
        if ($urandom_range(4) == 0)
            ticks = $urandom_range(reload, 0);
        else
            ticks = reload + 1 + $urandom_range(2, 0);
        send_ticks(ticks);
    endtask

    task automatic run_frames(input int budget, input int reload);
        int start;
        int len;
        start = items_sent;
        while (items_sent - start < budget) begin
            if ($urandom_range(11) == 0)
                len = $urandom_range(70, 60);
            else
                len = $urandom_range(8, 1);
            send_frame(len, reload);
        end
    endtask

    task automatic write_reload(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        scoreboard.set_reload(value);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (scoreboard.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_gaps(input bit on);
        @(negedge clk);
        gap_en = on;
        @(posedge clk);
    endtask

    initial
    begin
        int reload;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset reload of five ticks.
        send_item(igfa_pkg::OP_TICK, 8'hFF);        // empty store, nothing happens
        send_item(igfa_pkg::OP_BYTE, 8'h00);
        send_item(igfa_pkg::OP_BYTE, 8'hFF);
        send_item(igfa_pkg::OP_BYTE, 8'h80);
        send_item(igfa_pkg::OP_BYTE, 8'h01);
        send_ticks(6);                              // five countdown ticks, then the drain
        send_item(igfa_pkg::OP_TICK, 8'h00);        // timer at zero, store empty again
        send_item(igfa_pkg::OP_BYTE, 8'h7F);
        send_ticks(2);
        send_item(igfa_pkg::OP_BYTE, 8'h55);        // reloads the timer mid-countdown
        send_ticks(6);
        wait_idle();

        // Zero reload: the first tick after a byte releases the frame.
        write_reload(8'd0);
        run_frames(30, 0);
        wait_idle();

        // Largest reload: a short frame starts a long countdown and stays held,
        // so the next run extends it.
        write_reload(8'd255);
        send_item(igfa_pkg::OP_BYTE, 8'($urandom));
        send_item(igfa_pkg::OP_BYTE, 8'($urandom));
        send_ticks(4);
        wait_idle();

        // A stretch with no idling on either side.
        set_gaps(1'b0);
        write_reload(8'd1);
        run_frames(30, 1);
        wait_idle();
        set_gaps(1'b1);

        // Random reload; starts with a frame that overflows the store.
        reload = $urandom_range(12, 2);
        write_reload(8'(reload));
        send_frame(70, reload);
        run_frames(20, reload);
        wait_idle();

        if (scoreboard.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
